/* rtl/cmae_pkg.sv */
// cmae_pkg: shared types, codes and fixed-point helpers of the complex matrix engine
// no dependencies
package cmae_pkg;

  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int EXP_W       = 8;
  localparam int OPC_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [OPC_W-1:0] OPC_LOAD_A = 3'd0;
  localparam logic [OPC_W-1:0] OPC_LOAD_B = 3'd1;
  localparam logic [OPC_W-1:0] OPC_ADD    = 3'd2;
  localparam logic [OPC_W-1:0] OPC_SUB    = 3'd3;
  localparam logic [OPC_W-1:0] OPC_MUL    = 3'd4;
  localparam logic [OPC_W-1:0] OPC_POW    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 3'd3;

  typedef enum logic [2:0] {
    CLS_LOAD_A,
    CLS_LOAD_B,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_POW
  } cls_t;

  typedef struct packed {
    cls_t                     cls;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [EXP_W-1:0]         exp;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  // saturate a 33-bit sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] res;
    if (v[DATA_W] != v[DATA_W-1]) begin
      res = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // saturate a 64-bit value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [2*DATA_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > 64'sh000000007FFFFFFF) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -64'sh0000000080000000) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/cmae_ram.sv */
// cmae_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module cmae_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cmae_front.sv */
// cmae_front: accepts items, classifies them and holds them in a short queue
// depends on cmae_pkg
module cmae_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [cmae_pkg::OPC_W-1:0]        in_opcode,
  input  logic [cmae_pkg::IDX_W-1:0]        in_row_index,
  input  logic [cmae_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [cmae_pkg::DATA_W-1:0] in_real_part,
  input  logic signed [cmae_pkg::DATA_W-1:0] in_imag_part,
  input  logic [cmae_pkg::EXP_W-1:0]        in_exponent,
  output logic                              q_valid,
  output cmae_pkg::item_t                   q_item,
  input  logic                              q_pop
);

  cmae_pkg::item_t                   entry_r [cmae_pkg::QUEUE_DEPTH];
  logic [cmae_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [cmae_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [cmae_pkg::QCNT_W-1:0]       count_r;
  cmae_pkg::item_t                   cls_item;
  logic                              keep;
  logic                              in_range;
  logic                              enq;
  logic                              deq;

  assign in_full  = (count_r == cmae_pkg::QCNT_W'(cmae_pkg::QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = entry_r[rd_ptr_r];
  assign in_range = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);

  // decode: out-of-range loads and unused opcodes are dropped here
  always_comb begin
    cls_item.row = in_row_index;
    cls_item.col = in_col_index;
    cls_item.re  = in_real_part;
    cls_item.im  = in_imag_part;
    cls_item.exp = in_exponent;
    cls_item.cls = cmae_pkg::CLS_ADD;
    keep         = 1'b1;
    unique case (in_opcode)
      cmae_pkg::OPC_LOAD_A: begin
        cls_item.cls = cmae_pkg::CLS_LOAD_A;
        keep         = in_range;
      end
      cmae_pkg::OPC_LOAD_B: begin
        cls_item.cls = cmae_pkg::CLS_LOAD_B;
        keep         = in_range;
      end
      cmae_pkg::OPC_ADD: cls_item.cls = cmae_pkg::CLS_ADD;
      cmae_pkg::OPC_SUB: cls_item.cls = cmae_pkg::CLS_SUB;
      cmae_pkg::OPC_MUL: cls_item.cls = cmae_pkg::CLS_MUL;
      cmae_pkg::OPC_POW: cls_item.cls = cmae_pkg::CLS_POW;
      default: keep = 1'b0;
    endcase
  end

  assign enq = in_push && !in_full && keep;
  assign deq = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      entry_r[wr_ptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= wr_ptr_r + cmae_pkg::QPTR_W'(1);
      end
      if (deq) begin
        rd_ptr_r <= rd_ptr_r + cmae_pkg::QPTR_W'(1);
      end
      if (enq && !deq) begin
        count_r <= count_r + cmae_pkg::QCNT_W'(1);
      end else if (deq && !enq) begin
        count_r <= count_r - cmae_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/cmae_back.sv */
// cmae_back: sequencer that runs loads and matrix operations and holds the result register
// depends on cmae_pkg and cmae_ram
module cmae_back #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cmae_pkg::dims_t                    dims,
  input  logic                               q_valid,
  input  cmae_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [cmae_pkg::IDX_W-1:0]         out_row,
  output logic [cmae_pkg::IDX_W-1:0]         out_col,
  output logic signed [cmae_pkg::DATA_W-1:0] out_real,
  output logic signed [cmae_pkg::DATA_W-1:0] out_imag,
  output logic                               out_last_element,
  output logic                               out_status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = 2 * cmae_pkg::DATA_W;
  localparam int DW    = cmae_pkg::DATA_W;
  localparam int DMW   = cmae_pkg::DIM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AS_RD, ST_AS_WR, ST_CP_RD, ST_CP_WR,
    ST_MM_RD, ST_MM_MUL, ST_MM_TERM, ST_MM_ACC,
    ST_EM_RD, ST_EM_OUT, ST_ERR
  } state_t;

  typedef enum logic [1:0] {SRC_W, SRC_S, SRC_ID} src_t;

  state_t                  state_r;
  cmae_pkg::cls_t          mode_r;
  src_t                    em_src_r;
  logic                    src_w_r;
  logic [DMW-1:0]          n_r, k_r, m_r, r_r, c_r, i_r;
  logic [cmae_pkg::EXP_W-1:0] it_r, exp_r;
  logic signed [DW-1:0]    sr_r, si_r, tr_r, ti_r;
  logic signed [EW-1:0]    prr_r, pii_r, pri_r, pir_r;
  logic                    out_valid_r;

  logic [DMW-1:0]          ar, ac, br, bc;
  logic [AW-1:0]           rc_addr, ri_addr, ic_addr, ld_addr, x_addr, y_addr;
  logic                    a_we, b_we, w_we, s_we, last_i;
  logic [EW-1:0]           a_rdata, b_rdata, w_rdata, s_rdata, w_wdata, s_wdata;
  logic [AW-1:0]           a_raddr, b_raddr;
  logic [EW-1:0]           x_data, y_data, as_elem, acc_elem, em_elem;
  logic signed [DW-1:0]    as_re, as_im, acc_re, acc_im;
  logic signed [DW-1:0]    f_rr, f_ii, f_ri, f_ir;
  logic                    as_ok, mul_ok, pow_ok;

  function automatic logic [DMW-1:0] clamp(input logic [DMW-1:0] v);
    return (int'(v) > MAX_DIM) ? DMW'(MAX_DIM) : v;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [DMW-1:0] r, input logic [DMW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  assign ar = clamp(dims.a_rows);
  assign ac = clamp(dims.a_cols);
  assign br = clamp(dims.b_rows);
  assign bc = clamp(dims.b_cols);

  assign as_ok  = (ar == br) && (ac == bc) && (ar != '0) && (ac != '0);
  assign mul_ok = (ac == br) && (ar != '0) && (br != '0) && (bc != '0);
  assign pow_ok = (ar == ac) && (ar != '0);

  assign rc_addr = addr(r_r, c_r);
  assign ri_addr = addr(r_r, i_r);
  assign ic_addr = addr(i_r, c_r);
  assign ld_addr = addr({1'b0, q_item.row}, {1'b0, q_item.col});

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign a_we  = q_pop && (q_item.cls == cmae_pkg::CLS_LOAD_A);
  assign b_we  = q_pop && (q_item.cls == cmae_pkg::CLS_LOAD_B);

  // x operand is A (multiply) or the running power; y is B (multiply) or A
  assign x_addr  = (state_r == ST_MM_RD) ? ri_addr : rc_addr;
  assign y_addr  = (state_r == ST_MM_RD) ? ic_addr : rc_addr;
  assign a_raddr = (state_r == ST_MM_RD && mode_r == cmae_pkg::CLS_MUL) ? ri_addr : y_addr;
  assign b_raddr = y_addr;
  assign x_data  = (mode_r == cmae_pkg::CLS_MUL) ? a_rdata : (src_w_r ? w_rdata : s_rdata);
  assign y_data  = (mode_r == cmae_pkg::CLS_MUL) ? b_rdata : a_rdata;

  // element-wise add or subtract
  always_comb begin
    if (mode_r == cmae_pkg::CLS_SUB) begin
      as_re = cmae_pkg::sat33({a_rdata[DW-1], a_rdata[DW-1:0]} - {b_rdata[DW-1], b_rdata[DW-1:0]});
      as_im = cmae_pkg::sat33({a_rdata[EW-1], a_rdata[EW-1:DW]} - {b_rdata[EW-1], b_rdata[EW-1:DW]});
    end else begin
      as_re = cmae_pkg::sat33({a_rdata[DW-1], a_rdata[DW-1:0]} + {b_rdata[DW-1], b_rdata[DW-1:0]});
      as_im = cmae_pkg::sat33({a_rdata[EW-1], a_rdata[EW-1:DW]} + {b_rdata[EW-1], b_rdata[EW-1:DW]});
    end
  end
  assign as_elem = {as_im, as_re};

  // scaled products, then the complex term
  assign f_rr = cmae_pkg::sat64(prr_r >>> FRAC_BITS);
  assign f_ii = cmae_pkg::sat64(pii_r >>> FRAC_BITS);
  assign f_ri = cmae_pkg::sat64(pri_r >>> FRAC_BITS);
  assign f_ir = cmae_pkg::sat64(pir_r >>> FRAC_BITS);

  assign acc_re   = cmae_pkg::sat33({sr_r[DW-1], sr_r} + {tr_r[DW-1], tr_r});
  assign acc_im   = cmae_pkg::sat33({si_r[DW-1], si_r} + {ti_r[DW-1], ti_r});
  assign acc_elem = {acc_im, acc_re};
  assign last_i   = (i_r + DMW'(1) == k_r);

  assign w_we = (state_r == ST_AS_WR)
             || (state_r == ST_MM_ACC && last_i && (mode_r == cmae_pkg::CLS_MUL || !src_w_r));
  assign s_we = (state_r == ST_CP_WR)
             || (state_r == ST_MM_ACC && last_i && mode_r == cmae_pkg::CLS_POW && src_w_r);
  assign w_wdata = (state_r == ST_AS_WR) ? as_elem : acc_elem;
  assign s_wdata = (state_r == ST_CP_WR) ? a_rdata : acc_elem;

  always_comb begin
    case (em_src_r)
      SRC_W:   em_elem = w_rdata;
      SRC_S:   em_elem = s_rdata;
      default: em_elem = (r_r == c_r) ? {DW'(0), DW'(1) << FRAC_BITS} : '0;
    endcase
  end

  cmae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(ld_addr), .wdata({q_item.im, q_item.re}),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  cmae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(ld_addr), .wdata({q_item.im, q_item.re}),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  cmae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_w (
    .clk(clk), .we(w_we), .waddr(rc_addr), .wdata(w_wdata),
    .raddr(x_addr), .rdata(w_rdata)
  );
  cmae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_s (
    .clk(clk), .we(s_we), .waddr(rc_addr), .wdata(s_wdata),
    .raddr(x_addr), .rdata(s_rdata)
  );

  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          r_r  <= '0;
          c_r  <= '0;
          i_r  <= '0;
          sr_r <= '0;
          si_r <= '0;
          if (q_valid) begin
            mode_r <= q_item.cls;
            exp_r  <= q_item.exp;
            case (q_item.cls)
              cmae_pkg::CLS_ADD, cmae_pkg::CLS_SUB: begin
                n_r     <= ar;
                m_r     <= ac;
                state_r <= as_ok ? ST_AS_RD : ST_ERR;
              end
              cmae_pkg::CLS_MUL: begin
                n_r     <= ar;
                k_r     <= ac;
                m_r     <= bc;
                state_r <= mul_ok ? ST_MM_RD : ST_ERR;
              end
              cmae_pkg::CLS_POW: begin
                n_r      <= ar;
                k_r      <= ar;
                m_r      <= ar;
                src_w_r  <= 1'b0;
                it_r     <= cmae_pkg::EXP_W'(1);
                em_src_r <= SRC_ID;
                if (!pow_ok) begin
                  state_r <= ST_ERR;
                end else if (q_item.exp == '0) begin
                  state_r <= ST_EM_RD;
                end else begin
                  state_r <= ST_CP_RD;
                end
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_AS_RD: state_r <= ST_AS_WR;
        ST_AS_WR: begin
          em_src_r <= SRC_W;
          state_r  <= ST_AS_RD;
          if (c_r + DMW'(1) < m_r) begin
            c_r <= c_r + DMW'(1);
          end else begin
            c_r <= '0;
            if (r_r + DMW'(1) < n_r) begin
              r_r <= r_r + DMW'(1);
            end else begin
              r_r     <= '0;
              state_r <= ST_EM_RD;
            end
          end
        end
        ST_CP_RD: state_r <= ST_CP_WR;
        ST_CP_WR: begin
          em_src_r <= SRC_S;
          state_r  <= ST_CP_RD;
          if (c_r + DMW'(1) < m_r) begin
            c_r <= c_r + DMW'(1);
          end else begin
            c_r <= '0;
            if (r_r + DMW'(1) < n_r) begin
              r_r <= r_r + DMW'(1);
            end else begin
              r_r     <= '0;
              state_r <= (exp_r == cmae_pkg::EXP_W'(1)) ? ST_EM_RD : ST_MM_RD;
            end
          end
        end
        ST_MM_RD: state_r <= ST_MM_MUL;
        ST_MM_MUL: begin
          prr_r   <= EW'($signed(x_data[DW-1:0])) * EW'($signed(y_data[DW-1:0]));
          pii_r   <= EW'($signed(x_data[EW-1:DW])) * EW'($signed(y_data[EW-1:DW]));
          pri_r   <= EW'($signed(x_data[DW-1:0])) * EW'($signed(y_data[EW-1:DW]));
          pir_r   <= EW'($signed(x_data[EW-1:DW])) * EW'($signed(y_data[DW-1:0]));
          state_r <= ST_MM_TERM;
        end
        ST_MM_TERM: begin
          tr_r    <= cmae_pkg::sat33({f_rr[DW-1], f_rr} - {f_ii[DW-1], f_ii});
          ti_r    <= cmae_pkg::sat33({f_ri[DW-1], f_ri} + {f_ir[DW-1], f_ir});
          state_r <= ST_MM_ACC;
        end
        ST_MM_ACC: begin
          state_r <= ST_MM_RD;
          if (!last_i) begin
            sr_r <= acc_re;
            si_r <= acc_im;
            i_r  <= i_r + DMW'(1);
          end else begin
            sr_r <= '0;
            si_r <= '0;
            i_r  <= '0;
            if (c_r + DMW'(1) < m_r) begin
              c_r <= c_r + DMW'(1);
            end else begin
              c_r <= '0;
              if (r_r + DMW'(1) < n_r) begin
                r_r <= r_r + DMW'(1);
              end else begin
                r_r <= '0;
                if (mode_r == cmae_pkg::CLS_MUL) begin
                  em_src_r <= SRC_W;
                  state_r  <= ST_EM_RD;
                end else begin
                  // the product just written becomes the running power
                  src_w_r <= !src_w_r;
                  if (it_r + cmae_pkg::EXP_W'(1) < exp_r) begin
                    it_r <= it_r + cmae_pkg::EXP_W'(1);
                  end else begin
                    em_src_r <= src_w_r ? SRC_S : SRC_W;
                    state_r  <= ST_EM_RD;
                  end
                end
              end
            end
          end
        end
        ST_EM_RD: begin
          if (!out_valid_r || out_pop) begin
            state_r <= ST_EM_OUT;
          end
        end
        ST_EM_OUT: begin
          out_valid_r      <= 1'b1;
          out_row          <= r_r[cmae_pkg::IDX_W-1:0];
          out_col          <= c_r[cmae_pkg::IDX_W-1:0];
          out_real         <= em_elem[DW-1:0];
          out_imag         <= em_elem[EW-1:DW];
          out_status       <= 1'b0;
          out_last_element <= 1'b0;
          state_r          <= ST_EM_RD;
          if (c_r + DMW'(1) < m_r) begin
            c_r <= c_r + DMW'(1);
          end else begin
            c_r <= '0;
            if (r_r + DMW'(1) < n_r) begin
              r_r <= r_r + DMW'(1);
            end else begin
              r_r              <= '0;
              out_last_element <= 1'b1;
              state_r          <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          // wait for the result register to drain before loading the error item
          if (!out_valid_r) begin
            out_valid_r      <= 1'b1;
            out_row          <= '0;
            out_col          <= '0;
            out_real         <= '0;
            out_imag         <= '0;
            out_last_element <= 1'b1;
            out_status       <= 1'b1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/complex_matrix_arith_engine.sv */
// complex_matrix_arith_engine: top level, configuration registers and the front/back pair
// depends on cmae_pkg, cmae_front, cmae_back (and cmae_ram through cmae_back)
//
// Complex matrix engine over Q16.16 values (FRAC_BITS fractional bits). Load items
// write one element of A or B and pass through the front queue, so loads stream at
// one per cycle while the back keeps up. Compute items are run by the back sequencer
// one at a time: add/sub reads the operands and writes each result element, then
// streams the result out; multiply runs each multiply-accumulate step through read,
// four 32x32 products, scaled term and accumulate, then streams the result out; power
// n x n to exponent e copies A and then runs e-1 such matrix products (exponent 0 gives
// the identity). The single result register holds one output item, and the back waits
// while it is full and not popped. A four-entry queue sits between the front and the
// back; in_full rises once it fills while the back works. Shape errors give one item with status 1.
module complex_matrix_arith_engine #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input queue side
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [cmae_pkg::OPC_W-1:0]          in_opcode,
  input  logic [cmae_pkg::IDX_W-1:0]          in_row_index,
  input  logic [cmae_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [cmae_pkg::DATA_W-1:0]  in_real_part,
  input  logic signed [cmae_pkg::DATA_W-1:0]  in_imag_part,
  input  logic [cmae_pkg::EXP_W-1:0]          in_exponent,
  // result queue side
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [cmae_pkg::IDX_W-1:0]          out_row,
  output logic [cmae_pkg::IDX_W-1:0]          out_col,
  output logic signed [cmae_pkg::DATA_W-1:0]  out_real,
  output logic signed [cmae_pkg::DATA_W-1:0]  out_imag,
  output logic                                out_last_element,
  output logic                                out_status,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmae_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmae_pkg::DIM_W-1:0]          cfg_data
);

  cmae_pkg::dims_t dims_r;
  cmae_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // dimension registers, always ready; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cmae_pkg::CFG_A_ROWS: dims_r.a_rows <= cfg_data;
        cmae_pkg::CFG_A_COLS: dims_r.a_cols <= cfg_data;
        cmae_pkg::CFG_B_ROWS: dims_r.b_rows <= cfg_data;
        cmae_pkg::CFG_B_COLS: dims_r.b_cols <= cfg_data;
        default: dims_r <= dims_r;
      endcase
    end
  end

  // front: accept, classify, queue
  cmae_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_real_part(in_real_part), .in_imag_part(in_imag_part), .in_exponent(in_exponent),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: matrix storage, arithmetic and result register
  cmae_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .dims(dims_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_row(out_row), .out_col(out_col), .out_real(out_real), .out_imag(out_imag),
    .out_last_element(out_last_element), .out_status(out_status)
  );

endmodule
